FILE: hdl/rrua_pkg.sv
// Shared types and codes for the round-robin unit allocator.
package rrua_pkg;

   // Operation codes
   localparam logic [1:0] OP_REGISTER   = 2'd0;
   localparam logic [1:0] OP_SET_STATUS = 2'd1;
   localparam logic [1:0] OP_ALLOCATE   = 2'd2;
   localparam logic [1:0] OP_RELEASE    = 2'd3;

   // Unit status codes
   localparam logic [1:0] ST_AVAIL = 2'd0;
   localparam logic [1:0] ST_BUSY  = 2'd1;
   localparam logic [1:0] ST_MAINT = 2'd2;

   // Result codes
   localparam logic [2:0] RC_DONE       = 3'd0;
   localparam logic [2:0] RC_TABLE_FULL = 3'd1;
   localparam logic [2:0] RC_DUPLICATE  = 3'd2;
   localparam logic [2:0] RC_NOT_FOUND  = 3'd3;
   localparam logic [2:0] RC_NONE_AVAIL = 3'd4;
   localparam logic [2:0] RC_LOG_FULL   = 3'd5;
   localparam logic [2:0] RC_NOT_BUSY   = 3'd6;

   // Saturation point of task counts and grant numbers
   localparam logic [6:0] COUNT_MAX = 7'd127;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] unit_id;
      logic [1:0]  new_status;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_code;
      logic [15:0] granted_id;
      logic [6:0]  grant_number;
      logic [6:0]  unit_task_total;
   } rsp_type;

   // Top level to engine
   typedef struct packed {
      logic start;
      logic take;
   } eng_ctl_type;

   // Engine to top level
   typedef struct packed {
      logic busy;
      logic done;
   } eng_status_type;

endpackage

FILE: hdl/round_robin_unit_allocator.sv
// Round-robin unit allocator: request handshake, engine and result register.
//
// Keeps a table of up to UNIT_SLOTS worker units (id, status, task count) in a
// single-port-read synchronous memory and serves one operation at a time:
// register, set status, allocate (round robin from a rotating pointer) and
// release. Each operation gives exactly one response transfer. The table read
// port sets the timing, as one entry is read per cycle and compared the cycle
// after. A scan stops at the first entry that matches, or after all registered
// units have been read. Rejections that need no scan (table full, empty table,
// grant log full) go from idle straight to the reply state. The engine returns
// to idle as its response is loaded into the output register and takes the
// next request from there. A finished response sits in the output register, so
// the next request is taken while it waits.
// No clearing pass after reset: only entries below the fill count are read.
module round_robin_unit_allocator #(
   parameter int UNIT_SLOTS  = 16,
   parameter int GRANT_LIMIT = 64,
   parameter int ID_WIDTH    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rrua_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rrua_pkg::rsp_type rsp_data
);

   rrua_pkg::eng_ctl_type    eng_ctl;
   rrua_pkg::eng_status_type eng_status;
   rrua_pkg::rsp_type        eng_result;

   logic              rsp_valid_ff, rsp_valid_in;
   rrua_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              rsp_free;

   // Requests wait while the engine is working on one.
   assign req_stall     = eng_status.busy;
   assign eng_ctl.start = req_valid && !eng_status.busy;

   // Output register is free when empty or being drained this cycle.
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign eng_ctl.take = eng_status.done && rsp_free;

   rrua_engine #(
      .UNIT_SLOTS  (UNIT_SLOTS),
      .GRANT_LIMIT (GRANT_LIMIT),
      .ID_WIDTH    (ID_WIDTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .ctl    (eng_ctl),
      .cmd    (req_data),
      .status (eng_status),
      .result (eng_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_ctl.take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;   // transfer completed, nothing new
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/rrua_engine.sv
// Unit table memory with its scan, update and reply sequencer.
module rrua_engine #(
   parameter int UNIT_SLOTS  = 16,
   parameter int GRANT_LIMIT = 64,
   parameter int ID_WIDTH    = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rrua_pkg::eng_ctl_type   ctl,
   input  rrua_pkg::req_type       cmd,
   output rrua_pkg::eng_status_type status,
   output rrua_pkg::rsp_type       result
);

   localparam int SLOT_W = (UNIT_SLOTS > 1) ? $clog2(UNIT_SLOTS) : 1;
   localparam int CNT_W  = $clog2(UNIT_SLOTS + 1);
   localparam int GR_W   = $clog2(GRANT_LIMIT + 1);

   typedef struct packed {
      logic [ID_WIDTH-1:0] id;
      logic [1:0]          status;
      logic [6:0]          tasks;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_UPDATE = 4'b0100,
      S_REPLY  = 4'b1000
   } state_type;

   entry_type mem [UNIT_SLOTS];
   entry_type mem_rd_ff;

   state_type           state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [ID_WIDTH-1:0] key_ff, key_in;
   logic [1:0]          new_st_ff, new_st_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [GR_W-1:0]     grants_ff, grants_in;
   logic [SLOT_W-1:0]   rotate_ff, rotate_in;
   logic [SLOT_W-1:0]   issue_addr_ff, issue_addr_in;
   logic [CNT_W-1:0]    issue_cnt_ff, issue_cnt_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [SLOT_W-1:0]   rd_slot_ff, rd_slot_in;
   logic                hit_ff, hit_in;
   logic [SLOT_W-1:0]   hit_slot_ff, hit_slot_in;
   entry_type           hit_entry_ff, hit_entry_in;
   rrua_pkg::rsp_type   result_ff, result_in;

   logic              rd_en;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   entry_type         wr_data;
   logic              match;
   logic [6:0]        tasks_next;
   logic [GR_W:0]     grant_next;
   logic [6:0]        grant_num;

   assign match = (op_ff == rrua_pkg::OP_ALLOCATE) ?
                  (mem_rd_ff.status == rrua_pkg::ST_AVAIL) : (mem_rd_ff.id == key_ff);

   assign tasks_next = (hit_entry_ff.tasks < rrua_pkg::COUNT_MAX) ?
                       hit_entry_ff.tasks + 7'd1 : rrua_pkg::COUNT_MAX;
   assign grant_next = {1'b0, grants_ff} + (GR_W + 1)'(1);
   assign grant_num  = (32'(grant_next) > 32'(rrua_pkg::COUNT_MAX)) ?
                       rrua_pkg::COUNT_MAX : 7'(grant_next);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      new_st_in     = new_st_ff;
      count_in      = count_ff;
      grants_in     = grants_ff;
      rotate_in     = rotate_ff;
      issue_addr_in = issue_addr_ff;
      issue_cnt_in  = issue_cnt_ff;
      rd_pend_in    = 1'b0;
      rd_slot_in    = rd_slot_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      hit_entry_in  = hit_entry_ff;
      result_in     = result_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = hit_slot_ff;
      wr_data       = hit_entry_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               op_in         = cmd.op;
               key_in        = ID_WIDTH'(cmd.unit_id);
               new_st_in     = cmd.new_status;
               result_in     = '0;
               hit_in        = 1'b0;
               issue_cnt_in  = '0;
               issue_addr_in = (cmd.op == rrua_pkg::OP_ALLOCATE) ? rotate_ff : '0;
               state_in      = S_SCAN;
               if (cmd.op == rrua_pkg::OP_REGISTER && count_ff >= CNT_W'(UNIT_SLOTS)) begin
                  result_in.result_code = rrua_pkg::RC_TABLE_FULL;
                  state_in              = S_REPLY;
               end else if (cmd.op == rrua_pkg::OP_ALLOCATE && count_ff == '0) begin
                  result_in.result_code = rrua_pkg::RC_NONE_AVAIL;
                  state_in              = S_REPLY;
               end else if (cmd.op == rrua_pkg::OP_ALLOCATE &&
                            32'(grants_ff) >= 32'(GRANT_LIMIT)) begin
                  result_in.result_code = rrua_pkg::RC_LOG_FULL;
                  state_in              = S_REPLY;
               end
            end
         end
         S_SCAN: begin
            // one read issued per cycle; data compared the cycle after
            if (issue_cnt_ff < count_ff) begin
               rd_en        = 1'b1;
               rd_pend_in   = 1'b1;
               rd_slot_in   = issue_addr_ff;
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
               if (CNT_W'(issue_addr_ff) == count_ff - CNT_W'(1)) begin
                  issue_addr_in = '0;
               end else begin
                  issue_addr_in = issue_addr_ff + SLOT_W'(1);
               end
            end
            if (rd_pend_ff && match) begin
               hit_in       = 1'b1;
               hit_slot_in  = rd_slot_ff;
               hit_entry_in = mem_rd_ff;
               rd_pend_in   = 1'b0;
               state_in     = S_UPDATE;
            end else if (!rd_pend_ff && issue_cnt_ff == count_ff) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            state_in = S_REPLY;
            case (op_ff)
               rrua_pkg::OP_REGISTER: begin
                  if (hit_ff) begin
                     result_in.result_code = rrua_pkg::RC_DUPLICATE;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[SLOT_W-1:0];
                     wr_data  = '{id: key_ff, status: rrua_pkg::ST_AVAIL, tasks: 7'd0};
                     count_in = count_ff + CNT_W'(1);
                     result_in.result_code = rrua_pkg::RC_DONE;
                  end
               end
               rrua_pkg::OP_SET_STATUS: begin
                  if (hit_ff) begin
                     wr_en          = 1'b1;
                     wr_data.status = (new_st_ff > rrua_pkg::ST_MAINT) ?
                                      rrua_pkg::ST_MAINT : new_st_ff;
                     result_in.result_code = rrua_pkg::RC_DONE;
                  end else begin
                     result_in.result_code = rrua_pkg::RC_NOT_FOUND;
                  end
               end
               rrua_pkg::OP_ALLOCATE: begin
                  if (hit_ff) begin
                     wr_en          = 1'b1;
                     wr_data.status = rrua_pkg::ST_BUSY;
                     wr_data.tasks  = tasks_next;
                     grants_in      = grants_ff + GR_W'(1);
                     if (CNT_W'(hit_slot_ff) + CNT_W'(1) == count_ff) begin
                        rotate_in = '0;
                     end else begin
                        rotate_in = hit_slot_ff + SLOT_W'(1);
                     end
                     result_in.result_code     = rrua_pkg::RC_DONE;
                     result_in.granted_id      = 16'(hit_entry_ff.id);
                     result_in.grant_number    = grant_num;
                     result_in.unit_task_total = tasks_next;
                  end else begin
                     result_in.result_code = rrua_pkg::RC_NONE_AVAIL;
                  end
               end
               default: begin
                  if (!hit_ff) begin
                     result_in.result_code = rrua_pkg::RC_NOT_FOUND;
                  end else if (hit_entry_ff.status != rrua_pkg::ST_BUSY) begin
                     result_in.result_code = rrua_pkg::RC_NOT_BUSY;
                  end else begin
                     wr_en          = 1'b1;
                     wr_data.status = rrua_pkg::ST_AVAIL;
                     result_in.result_code = rrua_pkg::RC_DONE;
                  end
               end
            endcase
         end
         S_REPLY: begin
            if (ctl.take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Unit table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_ff <= mem[issue_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         grants_ff  <= '0;
         rotate_ff  <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         grants_ff  <= grants_in;
         rotate_ff  <= rotate_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      new_st_ff     <= new_st_in;
      issue_addr_ff <= issue_addr_in;
      issue_cnt_ff  <= issue_cnt_in;
      rd_slot_ff    <= rd_slot_in;
      hit_ff        <= hit_in;
      hit_slot_ff   <= hit_slot_in;
      hit_entry_ff  <= hit_entry_in;
      result_ff     <= result_in;
   end

   assign status.busy = (state_ff != S_IDLE);
   assign status.done = (state_ff == S_REPLY);
   assign result      = result_ff;

endmodule
